// File: rtl/wsfu_pkg.sv
// Package for the frame unmasker: channel payload types, the command passed
// from the header parser to the output stage, result and error codes.
// No dependencies.
`default_nettype none

package wsfu_pkg;

	// Depth of the command queue between parser and output stage.
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCw    = $clog2(QDepth + 1);

	// Seven-bit length codes.
	localparam logic [6:0] LenMax7 = 7'd125;
	localparam logic [6:0] Len16   = 7'd126;

	// Remaining extended-length bytes after the first one, and key bytes after the first.
	localparam logic [2:0] ExtCnt16 = 3'd1;
	localparam logic [2:0] ExtCnt64 = 3'd7;
	localparam logic [2:0] KeyCnt   = 3'd3;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_UNMASKED  = 2'd1,
		ERR_TRUNCATED = 2'd2
	} err_t;

	typedef enum logic [5:0] {
		PH_FIRST   = 6'b000001,
		PH_SECOND  = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_SKIP    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} rx_req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic        fin_flag;
		logic [3:0]  frame_opcode;
		logic [63:0] payload_length;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic [1:0]  error_code;
	} res_req_t;

	// One queued command: the payload data and key byte are combined in the output stage.
	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [3:0]  opcode;
		logic [63:0] length;
		logic [7:0]  data;
		logic [7:0]  key;
		logic        done;
		err_t        err;
	} cmd_t;

	// Write side of the queue.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} cmd_push_t;

endpackage

`default_nettype wire

// File: rtl/wsfu_front.sv
// Header parser: accepts received bytes, tracks the frame phase and issues
// one command per byte that produces a result. Depends on wsfu_pkg.
`default_nettype none

module wsfu_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire wsfu_pkg::rx_req_t  req,
	output wsfu_pkg::cmd_push_t     wr
);

	wsfu_pkg::phase_t phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic [63:0] len_q, len_d;
	logic [63:0] left_q, left_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] mask_q, mask_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [7:0]  b;
	logic        last;
	logic [7:0]  kb;

	assign b    = req.rx_byte;
	assign last = req.buffer_end;

	always_comb begin
		unique case (kidx_q)
			2'd0: kb = mask_q[31:24];
			2'd1: kb = mask_q[23:16];
			2'd2: kb = mask_q[15:8];
			2'd3: kb = mask_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		len_d    = len_q;
		left_d   = left_q;
		cnt_d    = cnt_q;
		mask_d   = mask_q;
		kidx_d   = kidx_q;
		wr       = '0;
		wr.cmd.kind = wsfu_pkg::KIND_ERROR;
		wr.cmd.err  = wsfu_pkg::ERR_TRUNCATED;
		wr.cmd.done = 1'b1;
		if (acc) begin
			unique case (phase_q)
				wsfu_pkg::PH_FIRST: begin
					fin_d    = b[7];
					opcode_d = b[3:0];
					if (last) begin
						wr.push = 1'b1;
					end else begin
						phase_d = wsfu_pkg::PH_SECOND;
					end
				end
				wsfu_pkg::PH_SECOND: begin
					if (!b[7]) begin
						wr.push    = 1'b1;
						wr.cmd.err = wsfu_pkg::ERR_UNMASKED;
						phase_d    = last ? wsfu_pkg::PH_FIRST : wsfu_pkg::PH_SKIP;
					end else if (last) begin
						wr.push = 1'b1;
						phase_d = wsfu_pkg::PH_FIRST;
					end else begin
						kidx_d = 2'd0;
						mask_d = '0;
						if (b[6:0] <= wsfu_pkg::LenMax7) begin
							len_d   = {57'd0, b[6:0]};
							cnt_d   = wsfu_pkg::KeyCnt;
							phase_d = wsfu_pkg::PH_KEY;
						end else begin
							len_d   = '0;
							cnt_d   = (b[6:0] == wsfu_pkg::Len16) ? wsfu_pkg::ExtCnt16
								: wsfu_pkg::ExtCnt64;
							phase_d = wsfu_pkg::PH_EXTLEN;
						end
					end
				end
				wsfu_pkg::PH_EXTLEN: begin
					len_d = {len_q[55:0], b};
					if (last) begin
						wr.push = 1'b1;
						phase_d = wsfu_pkg::PH_FIRST;
					end else if (cnt_q == 3'd0) begin
						cnt_d   = wsfu_pkg::KeyCnt;
						phase_d = wsfu_pkg::PH_KEY;
					end else begin
						cnt_d = cnt_q - 3'd1;
					end
				end
				wsfu_pkg::PH_KEY: begin
					mask_d = {mask_q[23:0], b};
					if (cnt_q != 3'd0) begin
						cnt_d = cnt_q - 3'd1;
						if (last) begin
							wr.push = 1'b1;
							phase_d = wsfu_pkg::PH_FIRST;
						end
					end else begin
						left_d = len_q;
						kidx_d = 2'd0;
						if (len_q == 64'd0) begin
							wr.push        = 1'b1;
							wr.cmd.kind    = wsfu_pkg::KIND_HEADER;
							wr.cmd.err     = wsfu_pkg::ERR_NONE;
							wr.cmd.fin     = fin_q;
							wr.cmd.opcode  = opcode_q;
							phase_d        = last ? wsfu_pkg::PH_FIRST : wsfu_pkg::PH_SKIP;
						end else if (last) begin
							wr.push = 1'b1;
							phase_d = wsfu_pkg::PH_FIRST;
						end else begin
							wr.push       = 1'b1;
							wr.cmd.kind   = wsfu_pkg::KIND_HEADER;
							wr.cmd.err    = wsfu_pkg::ERR_NONE;
							wr.cmd.fin    = fin_q;
							wr.cmd.opcode = opcode_q;
							wr.cmd.length = len_q;
							wr.cmd.done   = 1'b0;
							phase_d       = wsfu_pkg::PH_PAYLOAD;
						end
					end
				end
				wsfu_pkg::PH_PAYLOAD: begin
					kidx_d  = kidx_q + 2'd1;
					left_d  = left_q - 64'd1;
					wr.push = 1'b1;
					if (left_q == 64'd1) begin
						wr.cmd.kind = wsfu_pkg::KIND_PAYLOAD;
						wr.cmd.err  = wsfu_pkg::ERR_NONE;
						wr.cmd.data = b;
						wr.cmd.key  = kb;
						phase_d     = last ? wsfu_pkg::PH_FIRST : wsfu_pkg::PH_SKIP;
					end else if (last) begin
						phase_d = wsfu_pkg::PH_FIRST;
					end else begin
						wr.cmd.kind = wsfu_pkg::KIND_PAYLOAD;
						wr.cmd.err  = wsfu_pkg::ERR_NONE;
						wr.cmd.data = b;
						wr.cmd.key  = kb;
						wr.cmd.done = 1'b0;
					end
				end
				wsfu_pkg::PH_SKIP: begin
					if (last) begin
						phase_d = wsfu_pkg::PH_FIRST;
					end
				end
				default: begin
					phase_d = wsfu_pkg::PH_FIRST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfu_pkg::PH_FIRST;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			len_q    <= '0;
			left_q   <= '0;
			cnt_q    <= '0;
			mask_q   <= '0;
			kidx_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			len_q    <= len_d;
			left_q   <= left_d;
			cnt_q    <= cnt_d;
			mask_q   <= mask_d;
			kidx_q   <= kidx_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/wsfu_queue.sv
// Short command queue between the parser and the output stage.
// Register file with read and write pointers. Depends on wsfu_pkg.
`default_nettype none

module wsfu_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wsfu_pkg::cmd_push_t wr,
	input  wire logic                pop,
	output wsfu_pkg::cmd_t           head,
	output logic                     empty,
	output logic                     full
);

	wsfu_pkg::cmd_t                  mem_q [wsfu_pkg::QDepth];
	logic [wsfu_pkg::QAw-1:0]        wptr_q, rptr_q;
	logic [wsfu_pkg::QCw-1:0]        cnt_q;
	logic                            do_pop;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == wsfu_pkg::QCw'(wsfu_pkg::QDepth));
	assign head   = mem_q[rptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr.push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({wr.push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/wsfu_back.sv
// Output stage: takes commands from the queue, unmasks payload bytes and
// holds each result in an output register. Depends on wsfu_pkg.
`default_nettype none

module wsfu_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wsfu_pkg::cmd_t      head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output wsfu_pkg::res_req_t       res_data
);

	logic                  valid_q;
	wsfu_pkg::res_req_t    data_q;
	logic                  take;

	assign take      = !valid_q || !res_stall;
	assign pop       = take && !empty;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.result_kind    <= head.kind;
			data_q.fin_flag       <= head.fin;
			data_q.frame_opcode   <= head.opcode;
			data_q.payload_length <= head.length;
			data_q.payload_byte   <= head.data ^ head.key;
			data_q.frame_done     <= head.done;
			data_q.error_code     <= head.err;
		end
	end

endmodule

`default_nettype wire

// File: rtl/websocket_frame_unmasker.sv
// Top level of the client frame unmasker: parser, command queue and output stage.
// Depends on wsfu_pkg, wsfu_front, wsfu_queue and wsfu_back.
//
//   Channel | Direction | Handshake          | Payload
//   rx      | into      | rx_valid/rx_stall  | rx_data  (wsfu_pkg::rx_req_t)
//   res     | out of    | res_valid/res_stall| res_data (wsfu_pkg::res_req_t)
//
// The block takes one received byte per cycle while rx_stall is low. The parser
// decodes a byte in the cycle it is accepted and writes its command into the queue
// at that edge; the output register then loads it from the queue head once it holds no result or its result is taken.
// Reset clears the parse phase, the queue pointers and the output valid.
// While res_stall is high, queued results build up; rx_stall rises once the
// four-entry command queue is full, and falls the cycle after a result is taken.
`default_nettype none

module websocket_frame_unmasker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	output logic                    rx_stall,
	input  wire wsfu_pkg::rx_req_t  rx_data,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output wsfu_pkg::res_req_t      res_data
);

	logic                 rx_acc;
	wsfu_pkg::cmd_push_t  cmd_wr;
	wsfu_pkg::cmd_t       cmd_head;
	logic                 q_empty;
	logic                 q_full;
	logic                 q_pop;

	// The parser stalls only when there is no room for a command it may issue.
	assign rx_stall = q_full;
	assign rx_acc   = rx_valid && !rx_stall;

	// The parser holds the frame state and decides which bytes give results.
	wsfu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (rx_acc),
		.req    (rx_data),
		.wr     (cmd_wr)
	);

	// The queue decouples the parser from a stalled output.
	wsfu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.pop    (q_pop),
		.head   (cmd_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// The output stage applies the masking key and registers each result.
	wsfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (cmd_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

// File: rtl/wsfu_checker.sv
// Port-level checks for the frame unmasker, bound to the top level.
// Depends on wsfu_pkg and websocket_frame_unmasker.
`default_nettype none

module wsfu_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                rx_valid,
	input wire logic                rx_stall,
	input wire wsfu_pkg::rx_req_t   rx_data,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire wsfu_pkg::res_req_t  res_data
);

	// A stalled result stays offered and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// An error result always ends the frame and carries a nonzero code.
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == wsfu_pkg::KIND_ERROR
		|-> res_data.frame_done && res_data.error_code != wsfu_pkg::ERR_NONE)
		else $error("error result without frame end or code");

	// A header that ends the frame announces an empty payload.
	a_hdr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == wsfu_pkg::KIND_HEADER && res_data.frame_done
		|-> res_data.payload_length == 64'd0)
		else $error("final header with nonzero length");

	// Non-error results carry no error code, and kind three never appears.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.result_kind != 2'd3 &&
		(res_data.result_kind == wsfu_pkg::KIND_ERROR ||
		 res_data.error_code == wsfu_pkg::ERR_NONE))
		else $error("bad result kind or stray error code");

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (.*);

`default_nettype wire
